// ===== design/pidl_pkg.sv =====
// Shared request, error and cell command codes for the insert/delete list.
package pidl_pkg;

   localparam int REQ_BITS   = 3;
   localparam int POS_BITS   = 7;
   localparam int VALUE_BITS = 32;
   localparam int COUNT_BITS = 7;
   localparam int ERR_BITS   = 2;
   localparam int CMD_BITS   = 2;

   localparam int DEPTH_DEFAULT     = 64;
   localparam int WORD_BITS_DEFAULT = 32;

   localparam logic [REQ_BITS-1:0] REQ_APPEND = 3'd0;
   localparam logic [REQ_BITS-1:0] REQ_POP    = 3'd1;
   localparam logic [REQ_BITS-1:0] REQ_INSERT = 3'd2;
   localparam logic [REQ_BITS-1:0] REQ_ERASE  = 3'd3;
   localparam logic [REQ_BITS-1:0] REQ_READ   = 3'd4;
   localparam logic [REQ_BITS-1:0] REQ_WRITE  = 3'd5;
   localparam logic [REQ_BITS-1:0] REQ_CLEAR  = 3'd6;

   localparam logic [ERR_BITS-1:0] ERR_OK    = 2'd0;
   localparam logic [ERR_BITS-1:0] ERR_FULL  = 2'd1;
   localparam logic [ERR_BITS-1:0] ERR_EMPTY = 2'd2;
   localparam logic [ERR_BITS-1:0] ERR_RANGE = 2'd3;

   // Commands broadcast to every cell of the row.
   localparam logic [CMD_BITS-1:0] CELL_HOLD       = 2'd0;
   localparam logic [CMD_BITS-1:0] CELL_LOAD       = 2'd1;
   localparam logic [CMD_BITS-1:0] CELL_SHIFT_UP   = 2'd2;
   localparam logic [CMD_BITS-1:0] CELL_SHIFT_DOWN = 2'd3;

endpackage

// ===== design/pidl_cell.sv =====
// One storage cell of the list row: holds a word, loads or takes a neighbor's word.
module pidl_cell #(
   parameter int DEPTH      = pidl_pkg::DEPTH_DEFAULT,
   parameter int WORD_BITS  = pidl_pkg::WORD_BITS_DEFAULT,
   parameter int CELL_INDEX = 0
) (
   input  logic                               clock,
   input  logic [pidl_pkg::CMD_BITS-1:0]      cmd,
   input  logic [$clog2(DEPTH)-1:0]           index,
   input  logic [WORD_BITS-1:0]               new_word,
   input  logic [WORD_BITS-1:0]               lower_word,
   input  logic [WORD_BITS-1:0]               upper_word,
   output logic [WORD_BITS-1:0]               word
);
   import pidl_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

   logic [WORD_BITS-1:0] word_ff;
   logic [WORD_BITS-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      case (cmd)
         CELL_LOAD: begin
            if (MY_IDX == index) word_in = new_word;
         end
         CELL_SHIFT_UP: begin
            // insert: open a slot at index, later words move up one place
            if (MY_IDX == index) word_in = new_word;
            else if (MY_IDX > index) word_in = lower_word;
         end
         CELL_SHIFT_DOWN: begin
            // erase: close the slot at index
            if (MY_IDX >= index) word_in = upper_word;
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

// ===== design/positional_insert_delete_list.sv =====
// Top level of the positional insert/delete list: request decode, count and row of cells.
//
//   channel   ports                                        handshake
//   request   req_type, req_position, req_value            start && !busy
//   result    rsp_read_value, rsp_count, rsp_is_empty,     rsp_valid, one cycle
//             rsp_error
//
// One request per clock: busy stays low; any shift or load of cells happens in the
// accept cycle, so the whole row moves at once. The result appears on the
// cycle after acceptance for exactly one cycle. Synchronous reset clears the
// count and the result strobe; stored words stay undefined until written.
// The receiver cannot stall, so no result is ever held back.
module positional_insert_delete_list #(
   parameter int DEPTH     = pidl_pkg::DEPTH_DEFAULT,
   parameter int WORD_BITS = pidl_pkg::WORD_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [pidl_pkg::REQ_BITS-1:0]    req_type,
   input  logic [pidl_pkg::POS_BITS-1:0]    req_position,
   input  logic [pidl_pkg::VALUE_BITS-1:0]  req_value,
   output logic                             rsp_valid,
   output logic [pidl_pkg::VALUE_BITS-1:0]  rsp_read_value,
   output logic [pidl_pkg::COUNT_BITS-1:0]  rsp_count,
   output logic                             rsp_is_empty,
   output logic [pidl_pkg::ERR_BITS-1:0]    rsp_error
);
   import pidl_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int PW    = (CNT_W > POS_BITS) ? CNT_W : POS_BITS;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic                   rsp_valid_ff;
   logic [VALUE_BITS-1:0]  rsp_read_value_ff;
   logic [VALUE_BITS-1:0]  read_value_in;
   logic [COUNT_BITS-1:0]  rsp_count_ff;
   logic                   rsp_is_empty_ff;
   logic [ERR_BITS-1:0]    rsp_error_ff;
   logic [ERR_BITS-1:0]    error_in;

   logic                   accept;
   logic [CMD_BITS-1:0]    cell_cmd;
   logic [IDX_W-1:0]       cell_index;
   logic [WORD_BITS-1:0]   new_word;
   logic [PW-1:0]          pos_ext;
   logic [PW-1:0]          cnt_ext;
   logic [IDX_W-1:0]       pos_idx;
   logic                   is_full;
   logic                   in_range;

   logic [WORD_BITS-1:0]   cell_word [DEPTH];

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign new_word = WORD_BITS'(req_value);
   assign pos_ext  = PW'(req_position);
   assign cnt_ext  = PW'(count_ff);
   assign pos_idx  = pos_ext[IDX_W-1:0];
   assign is_full  = (count_ff == FULL_COUNT);
   assign in_range = (pos_ext < cnt_ext);

   always_comb begin
      cell_cmd      = CELL_HOLD;
      cell_index    = pos_idx;
      count_in      = count_ff;
      error_in      = ERR_OK;
      read_value_in = '0;
      if (accept) begin
         case (req_type)
            REQ_APPEND: begin
               if (is_full) begin
                  error_in = ERR_FULL;
               end else begin
                  cell_cmd   = CELL_LOAD;
                  cell_index = count_ff[IDX_W-1:0];
                  count_in   = count_ff + 1'b1;
               end
            end
            REQ_POP: begin
               if (count_ff == '0) error_in = ERR_EMPTY;
               else count_in = count_ff - 1'b1;
            end
            REQ_INSERT: begin
               if (is_full) begin
                  error_in = ERR_FULL;
               end else if (pos_ext > cnt_ext) begin
                  error_in = ERR_RANGE;
               end else begin
                  cell_cmd = CELL_SHIFT_UP;
                  count_in = count_ff + 1'b1;
               end
            end
            REQ_ERASE: begin
               if (!in_range) begin
                  error_in = ERR_RANGE;
               end else begin
                  cell_cmd = CELL_SHIFT_DOWN;
                  count_in = count_ff - 1'b1;
               end
            end
            REQ_READ: begin
               if (!in_range) error_in = ERR_RANGE;
               else read_value_in = VALUE_BITS'(cell_word[pos_idx]);
            end
            REQ_WRITE: begin
               if (!in_range) error_in = ERR_RANGE;
               else cell_cmd = CELL_LOAD;
            end
            REQ_CLEAR: begin
               count_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [WORD_BITS-1:0] lower_word;
      logic [WORD_BITS-1:0] upper_word;

      // end cells feed back their own word; only erase uses it, at the last cell
      if (g == 0) begin : g_first
         assign lower_word = cell_word[g];
      end else begin : g_lower
         assign lower_word = cell_word[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign upper_word = cell_word[g];
      end else begin : g_upper
         assign upper_word = cell_word[g+1];
      end

      pidl_cell #(
         .DEPTH      (DEPTH),
         .WORD_BITS  (WORD_BITS),
         .CELL_INDEX (g)
      ) u_cell (
         .clock      (clock),
         .cmd        (cell_cmd),
         .index      (cell_index),
         .new_word   (new_word),
         .lower_word (lower_word),
         .upper_word (upper_word),
         .word       (cell_word[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_read_value_ff <= read_value_in;
         rsp_count_ff      <= COUNT_BITS'(count_in);
         rsp_is_empty_ff   <= (count_in == '0);
         rsp_error_ff      <= error_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_is_empty   = rsp_is_empty_ff;
   assign rsp_error      = rsp_error_ff;

endmodule
